### rtl/lfs_pkg.sv
// Shared types and constants for the LED frame sequencer.
package lfs_pkg;

    // Item kinds carried on the action field.
    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_START   = 3'd2,
        ACT_BATTERY = 3'd3,
        ACT_STATUS  = 3'd4,
        ACT_DIRECT  = 3'd5
    } action_t;

    // Sequencer mode, one-hot.
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_STANDBY = 3'b010,
        MODE_WORKING = 3'b100
    } mode_t;

    // Overlay fields in a pattern word.
    localparam logic [15:0] BATTERY_MASK = 16'h3000;
    localparam logic [15:0] STATUS_MASK  = 16'hC000;
    localparam int          BATTERY_LSB  = 12;
    localparam int          STATUS_LSB   = 14;

endpackage

### rtl/led_frame_sequencer.sv
// LED frame sequencer: pattern table playback with battery and status overlays.
//
//   channel  ports            direction  payload
//   -------  ---------------  ---------  ------------------------------------------
//   input    s_valid/s_ready  in         action, frame_index, frame_word, counts, bits
//   result   m_valid/m_ready  out        drive_valid, drive_word, busy_res, start_error
//
// Each item's state update and result are computed in one pass
// from the sequencer registers and land in the result register at the accepting edge.
// One item per clock is sustained; s_ready drops only while a result waits unread.
// The pattern table reads through a registered port; per-entry valid bits make an
// entry not written since reset read with zero low bits, so no clearing pass is needed.
// Reset is synchronous and active low and clears all control state.
module led_frame_sequencer
    import lfs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_frame_index,
    input  logic [15:0] s_frame_word,
    input  logic [4:0]  s_frame_count,
    input  logic [15:0] s_hold_ticks,
    input  logic [15:0] s_repeat_count,
    input  logic [15:0] s_overlay_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_drive_valid,
    output logic [15:0] m_drive_word,
    output logic        m_busy_res,
    output logic        m_start_error
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Sequencer state.
    mode_t       mode_reg, mode_next;
    logic [4:0]  frames_left_reg, frames_left_next;
    logic [4:0]  frames_loaded_reg, frames_loaded_next;
    logic [15:0] hold_left_reg, hold_left_next;
    logic [15:0] hold_reload_reg, hold_reload_next;
    logic [15:0] repeats_left_reg, repeats_left_next;
    logic [1:0]  battery_reg, battery_next;
    logic [1:0]  status_reg, status_next;

    // Pattern table and its per-entry valid bits.
    logic [15:0]            table_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] entry_valid_reg;

    // Result register.
    logic        m_valid_reg;
    logic        drive_valid_reg, drive_valid_next;
    logic        direct_reg, direct_next;
    logic [15:0] direct_word_reg;
    logic [3:0]  ovl_reg;
    logic [15:0] mem_q_reg;
    logic        mem_q_valid_reg;
    logic        busy_reg;
    logic        err_reg, err_next;

    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [4:0]       frames_dec;
    logic [IDX_W+3:0] wr_ext;
    logic [IDX_W+4:0] rd_ext;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    action_t          act;

    assign act     = action_t'(s_action);
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Table addresses, widened before trimming so the slice is legal at any depth.
    assign frames_dec = frames_left_reg - 5'd1;
    assign wr_ext     = {{IDX_W{1'b0}}, s_frame_index};
    assign rd_ext     = {{IDX_W{1'b0}}, frames_dec};
    assign wr_idx     = wr_ext[IDX_W-1:0];
    assign rd_idx     = rd_ext[IDX_W-1:0];

    // Next state and result for the item on the input channel.
    always_comb begin
        mode_next          = mode_reg;
        frames_left_next   = frames_left_reg;
        frames_loaded_next = frames_loaded_reg;
        hold_left_next     = hold_left_reg;
        hold_reload_next   = hold_reload_reg;
        repeats_left_next  = repeats_left_reg;
        battery_next       = battery_reg;
        status_next        = status_reg;
        drive_valid_next   = 1'b0;
        direct_next        = 1'b0;
        err_next           = 1'b0;
        wr_en              = 1'b0;
        rd_en              = 1'b0;
        case (act)
            ACT_TICK: begin
                if (mode_reg == MODE_WORKING) begin
                    if (frames_left_reg == 5'd0) begin
                        // End of a pass: reload, and stop after the last repeat.
                        if (repeats_left_reg == 16'd0) begin
                            mode_next = MODE_STANDBY;
                        end
                        repeats_left_next = repeats_left_reg - 16'd1;
                        frames_left_next  = frames_loaded_reg;
                    end else if (hold_left_reg != 16'd0) begin
                        hold_left_next = hold_left_reg - 16'd1;
                    end else begin
                        frames_left_next = frames_dec;
                        hold_left_next   = hold_reload_reg;
                        drive_valid_next = 1'b1;
                        rd_en            = 1'b1;
                    end
                end
            end
            ACT_WRITE: begin
                wr_en = (32'(s_frame_index) < 32'(TABLE_DEPTH));
            end
            ACT_START: begin
                if (32'(s_frame_count) > 32'(TABLE_DEPTH)) begin
                    err_next = 1'b1;
                end else begin
                    frames_left_next   = s_frame_count;
                    frames_loaded_next = s_frame_count;
                    hold_left_next     = 16'd0;
                    hold_reload_next   = s_hold_ticks;
                    repeats_left_next  = s_repeat_count;
                    mode_next          = MODE_WORKING;
                end
            end
            ACT_BATTERY: begin
                battery_next = s_overlay_bits[BATTERY_LSB+1:BATTERY_LSB];
                if (frames_left_reg == 5'd0) begin
                    frames_left_next = 5'd1;
                end
                mode_next = MODE_WORKING;
            end
            ACT_STATUS: begin
                status_next = s_overlay_bits[STATUS_LSB+1:STATUS_LSB];
                if (frames_left_reg == 5'd0) begin
                    frames_left_next = 5'd1;
                end
                mode_next = MODE_WORKING;
            end
            ACT_DIRECT: begin
                drive_valid_next = 1'b1;
                direct_next      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control state and valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_IDLE;
            frames_left_reg   <= 5'd0;
            frames_loaded_reg <= 5'd0;
            hold_left_reg     <= 16'd0;
            hold_reload_reg   <= 16'd0;
            repeats_left_reg  <= 16'd0;
            battery_reg       <= 2'd0;
            status_reg        <= 2'd0;
            entry_valid_reg   <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg          <= mode_next;
                frames_left_reg   <= frames_left_next;
                frames_loaded_reg <= frames_loaded_next;
                hold_left_reg     <= hold_left_next;
                hold_reload_reg   <= hold_reload_next;
                repeats_left_reg  <= repeats_left_next;
                battery_reg       <= battery_next;
                status_reg        <= status_next;
                if (wr_en) begin
                    entry_valid_reg[wr_idx] <= 1'b1;
                end
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Table write and registered read.
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            table_mem[wr_idx] <= s_frame_word;
        end
        if (accept && rd_en) begin
            mem_q_reg       <= table_mem[rd_idx];
            mem_q_valid_reg <= entry_valid_reg[rd_idx];
        end
    end

    // Result payload, held while the result waits.
    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_valid_reg <= drive_valid_next;
            direct_reg      <= direct_next;
            direct_word_reg <= s_frame_word;
            ovl_reg         <= {status_reg, battery_reg};
            busy_reg        <= (mode_next != MODE_STANDBY);
            err_reg         <= err_next;
        end
    end

    // A played word keeps its low bits and takes the overlays on top.
    always_comb begin
        if (!drive_valid_reg) begin
            m_drive_word = 16'd0;
        end else if (direct_reg) begin
            m_drive_word = direct_word_reg;
        end else if (mem_q_valid_reg) begin
            m_drive_word = {ovl_reg, mem_q_reg[11:0]};
        end else begin
            m_drive_word = {ovl_reg, 12'd0};
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_valid = drive_valid_reg;
    assign m_busy_res    = busy_reg;
    assign m_start_error = err_reg;

`ifndef NO_ASSERTIONS
    // A rejected start leaves the mode as it was.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && act == ACT_START && 32'(s_frame_count) > 32'(TABLE_DEPTH))
        |=> (mode_reg == $past(mode_reg)))
        else $error("rejected start changed the mode");

    // The last pass ending drops busy on the result of that tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && act == ACT_TICK && mode_reg == MODE_WORKING &&
         frames_left_reg == 5'd0 && repeats_left_reg == 16'd0)
        |=> (m_valid && !m_busy_res && !m_drive_valid))
        else $error("final pass end did not report standby");

    // Pending frames never exceed the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(frames_left_reg) <= 32'(TABLE_DEPTH))
        else $error("frames_left beyond table depth");

    // An idle word is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_drive_valid) |-> (m_drive_word == 16'd0))
        else $error("drive word nonzero without drive_valid");

    // A start error never comes with a driven word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_start_error) |-> !m_drive_valid)
        else $error("start error with a driven word");
`endif

endmodule
